// ===== src/double_ended_queue_assert.svh =====
// Assertion macros used by the deque top level.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define DQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dq_pkg.sv =====
// Package with sizes, codes, ring helpers and control structs of the deque.
package dq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 3;

  // Operation codes carried in the input tuser
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP       = 3'd4;

  // Result status carried in the output tuser
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       push_front;
    logic       push_back;
    logic       pop_front;
    logic       pop_back;
    logic       dump_start;
    logic       set_pend;
    dq_status_e pend_status;
    logic       pend_mem;
    logic       load_pend;
    logic       walk_next;
  } dq_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic full;
    logic slot_free;
    logic walk_last;
  } dq_stat_t;

  // Ring position base + off, both below DEPTH
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Ring position one step before base
  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] base);
    logic [IDX_W-1:0] res;
    if (base == '0) begin
      res = IDX_W'(DEPTH - 1);
    end else begin
      res = base - IDX_W'(1);
    end
    return res;
  endfunction

endpackage

// ===== src/dq_ctrl.sv =====
// Controller state machine: decodes operations and sequences results.
module dq_ctrl import dq_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] opcode_i,
  input  dq_stat_t        stat_i,
  output logic            in_ready_o,
  output dq_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_RESULT = 3'b010,
    S_WALK   = 3'b100
  } dq_state_e;

  dq_state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Decode the accepted operation and drive the datapath
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.pend_status = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (opcode_i)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              cmd_o.set_pend = 1'b1;
              if (stat_i.full) begin
                cmd_o.pend_status = ST_FULL;
              end else begin
                cmd_o.push_front = (opcode_i == OP_PUSH_FRONT);
                cmd_o.push_back  = (opcode_i == OP_PUSH_BACK);
              end
              state_d = S_RESULT;
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              cmd_o.set_pend = 1'b1;
              if (stat_i.empty) begin
                cmd_o.pend_status = ST_EMPTY;
              end else begin
                cmd_o.pop_front = (opcode_i == OP_POP_FRONT);
                cmd_o.pop_back  = (opcode_i == OP_POP_BACK);
                cmd_o.pend_mem  = 1'b1;
              end
              state_d = S_RESULT;
            end
            OP_DUMP: begin
              if (stat_i.empty) begin
                cmd_o.set_pend    = 1'b1;
                cmd_o.pend_status = ST_EMPTY;
                state_d           = S_RESULT;
              end else begin
                cmd_o.dump_start = 1'b1;
                state_d          = S_WALK;
              end
            end
            default: begin
              // drop unused codes without a result
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_RESULT: begin
        if (stat_i.slot_free) begin
          cmd_o.load_pend = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_WALK: begin
        if (stat_i.slot_free) begin
          cmd_o.walk_next = 1'b1;
          if (stat_i.walk_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/dq_datapath.sv =====
// Datapath: entry ring, front pointer, count, dump walker and output register.
module dq_datapath import dq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dq_cmd_t                  cmd_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     out_ready_i,
  output dq_stat_t                 stat_o,
  output logic                     out_valid_o,
  output dq_status_e               out_status_o,
  output logic signed [DATA_W-1:0] out_value_o,
  output logic                     out_last_o
);

  logic signed [DATA_W-1:0] mem_q [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] walk_q, walk_d;
  logic [IDX_W-1:0] walk_inc;
  logic [CNT_W-1:0] count_m1;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic             wr_en, rd_en;

  dq_status_e pend_status_q;
  logic       pend_mem_q;

  logic                     out_valid_q, out_valid_d;
  dq_status_e               out_status_q;
  logic signed [DATA_W-1:0] out_value_q;
  logic                     out_last_q;
  logic                     load;

  assign walk_inc = walk_q + IDX_W'(1);
  assign count_m1 = count_q - CNT_W'(1);

  // Status toward the controller
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q == CNT_W'(DEPTH));
  assign stat_o.slot_free = !out_valid_q || out_ready_i;
  assign stat_o.walk_last = ((CNT_W'(walk_q) + CNT_W'(1)) == count_q);

  // Pick write and read addresses on the ring
  always_comb begin
    wr_en   = cmd_i.push_front || cmd_i.push_back;
    wr_addr = cmd_i.push_front ? ring_dec(front_q) : ring_add(front_q, count_q[IDX_W-1:0]);
    rd_en   = cmd_i.pop_front || cmd_i.pop_back || cmd_i.dump_start || cmd_i.walk_next;
    if (cmd_i.pop_back) begin
      rd_addr = ring_add(front_q, count_m1[IDX_W-1:0]);
    end else if (cmd_i.walk_next) begin
      rd_addr = ring_add(front_q, walk_inc);
    end else begin
      rd_addr = front_q;
    end
  end

  // Advance pointer, count and walker
  always_comb begin
    front_d = front_q;
    count_d = count_q;
    walk_d  = walk_q;
    if (cmd_i.push_front) begin
      front_d = ring_dec(front_q);
    end else if (cmd_i.pop_front) begin
      front_d = ring_add(front_q, IDX_W'(1));
    end
    if (wr_en) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.pop_front || cmd_i.pop_back) begin
      count_d = count_m1;
    end
    if (cmd_i.dump_start) begin
      walk_d = '0;
    end else if (cmd_i.walk_next) begin
      walk_d = walk_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  // Entry store with registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= value_i;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Hold walker and pending result
  always_ff @(posedge clk_i) begin
    walk_q <= walk_d;
    if (cmd_i.set_pend) begin
      pend_status_q <= cmd_i.pend_status;
      pend_mem_q    <= cmd_i.pend_mem;
    end
  end

  // Output register: load a result, drop it once transferred
  assign load = cmd_i.load_pend || cmd_i.walk_next;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_next) begin
      out_status_q <= ST_OK;
      out_value_q  <= rdata_q;
      out_last_q   <= stat_o.walk_last;
    end else if (cmd_i.load_pend) begin
      out_status_q <= pend_status_q;
      out_value_q  <= pend_mem_q ? rdata_q : '0;
      out_last_q   <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;
  assign out_last_o   = out_last_q;

endmodule

// ===== src/double_ended_queue.sv =====
// Top level of the bounded double-ended queue of signed words.
//
//   Channel  Dir  Carries
//   s_axis   in   tuser: opcode[2:0]; tdata: value[31:0]
//   m_axis   out  tuser: status[1:0]; tdata: value_res[31:0]; tlast: last_of_run
//
// A push or pop is taken in the idle state, which also accesses the entry
// store; the result state then loads the output register. A dump yields one
// entry per cycle while output is free, set by the store's single read port.
// Reset clears the front pointer, the count and the output valid; entries are
// not cleared. A stalled output holds the result; one more transfer is taken
// while a result waits, then input stalls until the output register frees.
`include "double_ended_queue_assert.svh"

module double_ended_queue import dq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic signed [DATA_W-1:0] s_axis_tdata,   // [31:0] value
  input  logic [OP_W-1:0]          s_axis_tuser,   // [2:0] opcode
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic signed [DATA_W-1:0] m_axis_tdata,   // [31:0] value_res
  output logic [1:0]               m_axis_tuser,   // [1:0] status
  output logic                     m_axis_tlast
);

  dq_cmd_t    cmd;
  dq_stat_t   stat;
  dq_status_e out_status;

  dq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .opcode_i   (s_axis_tuser),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  dq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .value_i      (s_axis_tdata),
    .out_ready_i  (m_axis_tready),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_value_o  (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tuser = out_status;

  // Empty and full never hold together
  `DQ_ASSERT_SAME(a_flags_excl, clk_i, rst_ni, 1'b1, !(stat.empty && stat.full), "empty and full both set")

  // An empty or full result is the last one and carries zero
  `DQ_ASSERT_SAME(a_err_result, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tlast && (m_axis_tdata == '0), "error result not last or not zero")

  // A push or pop transfer stalls the input for its result cycle
  `DQ_ASSERT_NEXT(a_busy_after_op, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_PUSH_FRONT || s_axis_tuser == OP_PUSH_BACK || s_axis_tuser == OP_POP_FRONT || s_axis_tuser == OP_POP_BACK), !s_axis_tready, "input ready right after an operation")

  // A push that found room leaves the queue non-empty
  `DQ_ASSERT_NEXT(a_push_fills, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && !stat.full && (s_axis_tuser == OP_PUSH_FRONT || s_axis_tuser == OP_PUSH_BACK), !stat.empty, "queue empty after a push")

endmodule
